@@ design/c6502_pkg.sv @@
// ----------------------------------------------------------------------------
// c6502_pkg - shared types and codes for the 6502 execute unit
// Operation and branch-condition codes, status bit positions, and the
// request and response payload structs carried on the stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

package c6502_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned PC_W   = 16;
    localparam int unsigned OP_W   = 5;
    localparam int unsigned COND_W = 3;

    // Status byte bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    typedef enum logic [OP_W-1:0] {
        OP_ADC    = 5'd0,
        OP_SBC    = 5'd1,
        OP_AND    = 5'd2,
        OP_CMP    = 5'd3,
        OP_CPX    = 5'd4,
        OP_CPY    = 5'd5,
        OP_BIT    = 5'd6,
        OP_ASL_A  = 5'd7,
        OP_ASL_M  = 5'd8,
        OP_CLC    = 5'd9,
        OP_CLD    = 5'd10,
        OP_CLI    = 5'd11,
        OP_CLV    = 5'd12,
        OP_BRANCH = 5'd13,
        OP_LDA    = 5'd14,
        OP_LDX    = 5'd15,
        OP_LDY    = 5'd16
    } t_op;

    // Branch condition: bits [2:1] pick the flag, bit 0 set means "branch if set"
    typedef enum logic [1:0] {
        CSEL_N = 2'd0,
        CSEL_V = 2'd1,
        CSEL_C = 2'd2,
        CSEL_Z = 2'd3
    } t_cond_sel;

    typedef struct packed {
        logic [OP_W-1:0]          req_type;
        logic [DATA_W-1:0]        operand;
        logic [COND_W-1:0]        branch_cond;
        logic [PC_W-1:0]          next_pc;
        logic signed [DATA_W-1:0] rel_offset;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              mem_write;
        logic [DATA_W-1:0] flags;
        logic [PC_W-1:0]   target_pc;
        logic              branch_taken;
        logic [1:0]        extra_cycles;
    } t_rsp;

endpackage

`default_nettype wire

@@ design/c6502_stream_if.sv @@
// ----------------------------------------------------------------------------
// c6502_stream_if - valid/ready stream channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface c6502_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/cpu6502_alu_flags_branch_core.sv @@
// ----------------------------------------------------------------------------
// cpu6502_alu_flags_branch_core - 6502 execute unit: ALU, flags and branches
// Holds A, X, Y and the status byte; executes one decoded operation per
// transfer and returns one response per request.
//
// Usage:
//   i_req : request channel (sink). Payload: req_type, operand, branch_cond,
//           next_pc, rel_offset. Transfer when valid and ready are high.
//   o_rsp : response channel (source). Payload: result_value, mem_write,
//           flags, target_pc, branch_taken, extra_cycles.
//   Each request passes through the input register, then the result
//   register, before its response is offered on o_rsp. Throughput: one
//   request per cycle while o_rsp.ready stays high; the execute logic is
//   one 8-bit add or compare plus a 16-bit PC add.
//   Each request sees the A/X/Y/flags left by the one before, as the
//   architectural registers are written in the same edge as the result.
//   Reset (i_rst_n low, synchronous): A, X, Y and flags go to zero, both
//   stages empty. Stall: while o_rsp.ready is low with a response held, the
//   request in the input register waits; i_req.ready then drops once that
//   register is full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_alu_flags_branch_core
    import c6502_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    c6502_stream_if.sink         i_req,
    c6502_stream_if.source       o_rsp
);

    // Input stage
    logic        r_in_valid;
    t_req        r_in;

    // Architectural state
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_y;
    logic [DATA_W-1:0] r_flags;

    // Result stage
    logic        r_out_valid;
    t_rsp        r_out;

    logic        advance;

    // Input stage moves on when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // ---- execute logic ----
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] n_x;
    logic [DATA_W-1:0] n_y;
    logic [DATA_W-1:0] n_flags;
    t_rsp              n_out;

    logic [DATA_W-1:0] add_b;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W-1:0] cmp_reg;
    logic [DATA_W:0]   cmp_diff;
    logic [DATA_W-1:0] shl_src;
    logic [DATA_W-1:0] shl_res;
    logic [PC_W-1:0]   br_target;
    logic              cond_flag;
    logic              cond_hit;

    always_comb begin
        // ADC/SBC share one adder; SBC adds the ones' complement
        add_b   = (r_in.req_type == OP_SBC) ? ~r_in.operand : r_in.operand;
        add_sum = {1'b0, r_acc} + {1'b0, add_b} + {{DATA_W{1'b0}}, r_flags[FLAG_C]};

        // Compare source register
        case (r_in.req_type)
            OP_CPX:  cmp_reg = r_x;
            OP_CPY:  cmp_reg = r_y;
            default: cmp_reg = r_acc;
        endcase
        cmp_diff = {1'b0, cmp_reg} - {1'b0, r_in.operand};

        shl_src = (r_in.req_type == OP_ASL_M) ? r_in.operand : r_acc;
        shl_res = {shl_src[DATA_W-2:0], 1'b0};

        // Branch condition and target (wraps modulo 64K)
        unique case (t_cond_sel'(r_in.branch_cond[2:1]))
            CSEL_N:  cond_flag = r_flags[FLAG_N];
            CSEL_V:  cond_flag = r_flags[FLAG_V];
            CSEL_C:  cond_flag = r_flags[FLAG_C];
            CSEL_Z:  cond_flag = r_flags[FLAG_Z];
            default: cond_flag = r_flags[FLAG_Z];
        endcase
        cond_hit  = r_in.branch_cond[0] ? cond_flag : !cond_flag;
        br_target = r_in.next_pc
                  + {{(PC_W-DATA_W){r_in.rel_offset[DATA_W-1]}}, r_in.rel_offset};
    end

    always_comb begin
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_flags = r_flags;

        n_out.mem_write    = 1'b0;
        n_out.target_pc    = r_in.next_pc;
        n_out.branch_taken = 1'b0;
        n_out.extra_cycles = 2'd0;

        unique case (r_in.req_type) inside
            OP_ADC, OP_SBC: begin
                n_acc           = add_sum[DATA_W-1:0];
                n_flags[FLAG_C] = add_sum[DATA_W];
                n_flags[FLAG_V] = ~(r_acc[DATA_W-1] ^ add_b[DATA_W-1])
                                & (r_acc[DATA_W-1] ^ add_sum[DATA_W-1]);
                n_flags[FLAG_Z] = (add_sum[DATA_W-1:0] == '0);
                n_flags[FLAG_N] = add_sum[DATA_W-1];
            end
            OP_AND: begin
                n_acc           = r_acc & r_in.operand;
                n_flags[FLAG_Z] = ((r_acc & r_in.operand) == '0);
                n_flags[FLAG_N] = r_acc[DATA_W-1] & r_in.operand[DATA_W-1];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                n_flags[FLAG_C] = !cmp_diff[DATA_W];
                n_flags[FLAG_Z] = (cmp_diff[DATA_W-1:0] == '0);
                n_flags[FLAG_N] = cmp_diff[DATA_W-1];
            end
            OP_BIT: begin
                n_flags[FLAG_Z] = ((r_acc & r_in.operand) == '0);
                n_flags[FLAG_N] = r_in.operand[7];
                n_flags[FLAG_V] = r_in.operand[6];
            end
            OP_ASL_A, OP_ASL_M: begin
                if (r_in.req_type == OP_ASL_A) begin
                    n_acc = shl_res;
                end else begin
                    n_out.mem_write = 1'b1;
                end
                n_flags[FLAG_C] = shl_src[DATA_W-1];
                n_flags[FLAG_Z] = (shl_res == '0);
                n_flags[FLAG_N] = shl_res[DATA_W-1];
            end
            OP_CLC: n_flags[FLAG_C] = 1'b0;
            OP_CLD: n_flags[FLAG_D] = 1'b0;
            OP_CLI: n_flags[FLAG_I] = 1'b0;
            OP_CLV: n_flags[FLAG_V] = 1'b0;
            OP_BRANCH: begin
                if (cond_hit) begin
                    n_out.target_pc    = br_target;
                    n_out.branch_taken = 1'b1;
                    // a page cross raises extra_cycles
                    n_out.extra_cycles = (br_target[PC_W-1:DATA_W]
                                          != r_in.next_pc[PC_W-1:DATA_W]) ? 2'd2 : 2'd1;
                end
            end
            OP_LDA, OP_LDX, OP_LDY: begin
                if (r_in.req_type == OP_LDA) n_acc = r_in.operand;
                if (r_in.req_type == OP_LDX) n_x   = r_in.operand;
                if (r_in.req_type == OP_LDY) n_y   = r_in.operand;
                n_flags[FLAG_Z] = (r_in.operand == '0);
                n_flags[FLAG_N] = r_in.operand[DATA_W-1];
            end
            default: ; // unused codes leave everything alone
        endcase

        // memory ASL returns the shifted byte, everything else the accumulator
        n_out.result_value = (r_in.req_type == OP_ASL_M) ? shl_res : n_acc;
        n_out.flags        = n_flags;
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_flags     <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_acc       <= n_acc;
                r_x         <= n_x;
                r_y         <= n_y;
                r_flags     <= n_flags;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
